// ===== design/sip_pkg.sv =====
// sip_pkg: widths, types and pipeline constants of the segment intersection block
// used by the channel interfaces and the top level; no dependencies

package sip_pkg;

   localparam int COORD_BITS = 24;
   localparam int FRAC_BITS  = 16;

   // direction and offset vectors need one bit more than a coordinate
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int NUM_W  = PROD_W + 1;
   // magnitude of a denominator or numerator
   localparam int MAG_W  = NUM_W - 1;

   localparam int FRONT_STAGES = 4;
   localparam int STAGES       = FRONT_STAGES + FRAC_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [NUM_W-1:0]      num_type;
   typedef logic        [MAG_W-1:0]      mag_type;
   typedef logic        [MAG_W:0]        shl_type;
   typedef logic        [FRAC_BITS-1:0]  frac_type;
   typedef logic        [STAGES-1:0]     stage_vec_type;

endpackage

// ===== design/sip_req_if.sv =====
// sip_req_if: input channel carrying one pair of segments per item
// depends on sip_pkg

interface sip_req_if;
   logic                valid;
   logic                ready;
   sip_pkg::coord_type  track_start_east;
   sip_pkg::coord_type  track_start_north;
   sip_pkg::coord_type  track_end_east;
   sip_pkg::coord_type  track_end_north;
   sip_pkg::coord_type  contour_start_east;
   sip_pkg::coord_type  contour_start_north;
   sip_pkg::coord_type  contour_end_east;
   sip_pkg::coord_type  contour_end_north;

   modport source (
      output valid, track_start_east, track_start_north, track_end_east, track_end_north,
      output contour_start_east, contour_start_north, contour_end_east, contour_end_north,
      input  ready
   );

   modport sink (
      input  valid, track_start_east, track_start_north, track_end_east, track_end_north,
      input  contour_start_east, contour_start_north, contour_end_east, contour_end_north,
      output ready
   );
endinterface

// ===== design/sip_rsp_if.sv =====
// sip_rsp_if: result channel carrying the hit flag and track fraction
// depends on sip_pkg

interface sip_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   sip_pkg::frac_type  t_fraction;

   modport source (
      output valid, hit, t_fraction,
      input  ready
   );

   modport sink (
      input  valid, hit, t_fraction,
      output ready
   );
endinterface

// ===== design/segment_intersection_param.sv =====
// segment_intersection_param: pipelined exact 2d segment intersection test
// depends on sip_pkg, sip_req_if and sip_rsp_if

// One item is a track segment and a contour segment with signed integer
// coordinates. The block returns one result per item, in order: hit is 1
// when the track parameter t and the contour parameter s both lie in
// [0,1), judged exactly in integers (a parallel, collinear or zero-length
// pair never hits; touching at a start point hits, at a far end point does
// not), and t_fraction is floor(t * 2^FRAC_BITS) on a hit and 0 otherwise.
// Throughput is one item per cycle unless every stage is full and rsp_ch is
// not ready. Differences, six products, the cross-product sums and the range
// test take one stage each, then the restoring division of t produces one
// quotient bit in each of FRAC_BITS stages. Every stage has its own valid bit
// and moves when the output drains or when it or some stage downstream of it
// is empty, so bubbles collapse and the block keeps taking items while a
// finished result waits on rsp_ch, as long as some stage is empty.

module segment_intersection_param (
   input  logic     clock,
   input  logic     reset,
   sip_req_if.sink   req_ch,
   sip_rsp_if.source rsp_ch
);

   localparam int F  = sip_pkg::FRAC_BITS;
   localparam int NS = sip_pkg::STAGES;

   // per stage valid and advance
   sip_pkg::stage_vec_type v_ff, v_in, adv;

   // stage 1: direction and offset vectors
   sip_pkg::diff_type s1x_ff, s1y_ff, s2x_ff, s2y_ff, dx_ff, dy_ff;
   // stage 2: products
   sip_pkg::prod_type p_den_a_ff, p_den_b_ff, p_s_a_ff, p_s_b_ff, p_t_a_ff, p_t_b_ff;
   // stage 3: denominator and numerators
   sip_pkg::num_type  den_ff, snum_ff, tnum_ff;
   // stage 4: range test and folded magnitudes
   logic              hit4_ff, hit4_in;
   sip_pkg::mag_type  den4_ff, den4_in, rem4_ff, rem4_in;
   // division stages
   logic              div_hit_ff [F];
   sip_pkg::mag_type  div_den_ff [F];
   sip_pkg::mag_type  div_rem_ff [F];
   sip_pkg::frac_type div_q_ff   [F];
   sip_pkg::mag_type  div_rem_in [F];
   sip_pkg::frac_type div_q_in   [F];

   // a stage may move when the output drains or when it or any later stage is empty
   always_comb begin
      for (int k = 0; k < NS; k++) begin
         adv[k] = rsp_ch.ready ||
                  (|(~v_ff & (sip_pkg::stage_vec_type'({NS{1'b1}}) << k)));
      end
   end

   always_comb begin
      v_in[0] = adv[0] ? req_ch.valid : v_ff[0];
      for (int k = 1; k < NS; k++) begin
         v_in[k] = adv[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ch.ready = adv[0];

   // stage 1: exact differences
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1x_ff <= sip_pkg::diff_type'(req_ch.track_end_east)
                 - sip_pkg::diff_type'(req_ch.track_start_east);
         s1y_ff <= sip_pkg::diff_type'(req_ch.track_end_north)
                 - sip_pkg::diff_type'(req_ch.track_start_north);
         s2x_ff <= sip_pkg::diff_type'(req_ch.contour_end_east)
                 - sip_pkg::diff_type'(req_ch.contour_start_east);
         s2y_ff <= sip_pkg::diff_type'(req_ch.contour_end_north)
                 - sip_pkg::diff_type'(req_ch.contour_start_north);
         dx_ff  <= sip_pkg::diff_type'(req_ch.track_start_east)
                 - sip_pkg::diff_type'(req_ch.contour_start_east);
         dy_ff  <= sip_pkg::diff_type'(req_ch.track_start_north)
                 - sip_pkg::diff_type'(req_ch.contour_start_north);
      end
   end

   // stage 2: six signed products
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         p_den_a_ff <= sip_pkg::prod_type'(s1x_ff) * sip_pkg::prod_type'(s2y_ff);
         p_den_b_ff <= sip_pkg::prod_type'(s2x_ff) * sip_pkg::prod_type'(s1y_ff);
         p_s_a_ff   <= sip_pkg::prod_type'(s1x_ff) * sip_pkg::prod_type'(dy_ff);
         p_s_b_ff   <= sip_pkg::prod_type'(s1y_ff) * sip_pkg::prod_type'(dx_ff);
         p_t_a_ff   <= sip_pkg::prod_type'(s2x_ff) * sip_pkg::prod_type'(dy_ff);
         p_t_b_ff   <= sip_pkg::prod_type'(s2y_ff) * sip_pkg::prod_type'(dx_ff);
      end
   end

   // stage 3: cross-product differences
   always_ff @(posedge clock) begin
      if (adv[2]) begin
         den_ff  <= sip_pkg::num_type'(p_den_a_ff) - sip_pkg::num_type'(p_den_b_ff);
         snum_ff <= sip_pkg::num_type'(p_s_a_ff)   - sip_pkg::num_type'(p_s_b_ff);
         tnum_ff <= sip_pkg::num_type'(p_t_a_ff)   - sip_pkg::num_type'(p_t_b_ff);
      end
   end

   // stage 4: range test on unfolded values, magnitudes for the divider
   always_comb begin
      logic             den_neg;
      logic             pos_ok;
      logic             neg_ok;
      sip_pkg::num_type zero;
      zero    = '0;
      den_neg = den_ff[sip_pkg::NUM_W-1];
      // positive denominator: 0 <= num < den
      pos_ok  = (snum_ff >= zero) && (snum_ff < den_ff) &&
                (tnum_ff >= zero) && (tnum_ff < den_ff);
      // negative denominator: den < num <= 0
      neg_ok  = (snum_ff <= zero) && (snum_ff > den_ff) &&
                (tnum_ff <= zero) && (tnum_ff > den_ff);
      hit4_in = (den_ff != zero) && (den_neg ? neg_ok : pos_ok);
      if (hit4_in) begin
         den4_in = den_neg ? sip_pkg::mag_type'(-den_ff)  : sip_pkg::mag_type'(den_ff);
         rem4_in = den_neg ? sip_pkg::mag_type'(-tnum_ff) : sip_pkg::mag_type'(tnum_ff);
      end else begin
         // zero remainder over a nonzero divisor keeps the quotient at zero
         den4_in = '1;
         rem4_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         hit4_ff <= hit4_in;
         den4_ff <= den4_in;
         rem4_ff <= rem4_in;
      end
   end

   // restoring division, one quotient bit per stage
   always_comb begin
      for (int k = 0; k < F; k++) begin
         sip_pkg::shl_type  shl;
         sip_pkg::mag_type  den_src;
         sip_pkg::frac_type q_src;
         logic              ge;
         shl     = (k == 0) ? {rem4_ff, 1'b0} : {div_rem_ff[(k == 0) ? 0 : k-1], 1'b0};
         den_src = (k == 0) ? den4_ff : div_den_ff[(k == 0) ? 0 : k-1];
         q_src   = (k == 0) ? '0 : div_q_ff[(k == 0) ? 0 : k-1];
         ge      = shl >= {1'b0, den_src};
         div_rem_in[k] = ge ? sip_pkg::mag_type'(shl - {1'b0, den_src})
                            : sip_pkg::mag_type'(shl);
         div_q_in[k]   = {q_src[F-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < F; k++) begin
         if (adv[sip_pkg::FRONT_STAGES + k]) begin
            div_rem_ff[k] <= div_rem_in[k];
            div_q_ff[k]   <= div_q_in[k];
            div_den_ff[k] <= (k == 0) ? den4_ff : div_den_ff[(k == 0) ? 0 : k-1];
            div_hit_ff[k] <= (k == 0) ? hit4_ff : div_hit_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   // last division stage is the output register
   assign rsp_ch.valid      = v_ff[NS-1];
   assign rsp_ch.hit        = div_hit_ff[F-1];
   assign rsp_ch.t_fraction = div_q_ff[F-1];

`ifndef SYNTH
   // input only stalls when no stage has a bubble
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (&v_ff))
      else $error("input stalled while the pipeline has an empty stage");

   // a hit enters the divider with a proper fraction
   a_frac_entry: assert property (@(posedge clock) disable iff (reset)
      (v_ff[3] && hit4_ff) |-> (rem4_ff < den4_ff))
      else $error("track numerator not below denominator on a hit");

   // a miss enters the divider so that its quotient stays zero
   a_miss_entry: assert property (@(posedge clock) disable iff (reset)
      (v_ff[3] && !hit4_ff) |-> ((rem4_ff == '0) && (den4_ff != '0)))
      else $error("miss does not force a zero quotient");

   // remainder at the last division step stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      v_ff[NS-1] |-> (div_rem_ff[F-1] < div_den_ff[F-1]))
      else $error("division remainder out of range");

   // a valid result carries a zero fraction whenever it misses
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (v_ff[NS-1] && !div_hit_ff[F-1]) |-> (div_q_ff[F-1] == '0))
      else $error("nonzero fraction on a miss");
`endif

endmodule

// ===== tb/sv/segment_intersection_param_checker.sv =====
// segment_intersection_param_checker: watches both channels, predicts each result
// depends on sip_pkg, sip_req_if and sip_rsp_if
`timescale 1ns / 1ps

module segment_intersection_param_checker (
   input  logic      clock,
   input  logic      reset,
   sip_req_if        req_ch,
   sip_rsp_if        rsp_ch,
   output int        fail_count,
   output int        pending
);

   typedef struct {
      logic              hit;
      sip_pkg::frac_type t_fraction;
   } crossing_type;

   crossing_type crossing_q[$];

   // exact integer crossing test; products fit easily in 64 bits
   function automatic crossing_type intersect_pair(
      input sip_pkg::coord_type tse, input sip_pkg::coord_type tsn,
      input sip_pkg::coord_type tee, input sip_pkg::coord_type ten,
      input sip_pkg::coord_type cse, input sip_pkg::coord_type csn,
      input sip_pkg::coord_type cee, input sip_pkg::coord_type cen
   );
      longint s1x, s1y, s2x, s2y, dx, dy;
      longint den, snum, tnum, rem;
      crossing_type c;
      s1x = longint'(tee) - longint'(tse);
      s1y = longint'(ten) - longint'(tsn);
      s2x = longint'(cee) - longint'(cse);
      s2y = longint'(cen) - longint'(csn);
      dx  = longint'(tse) - longint'(cse);
      dy  = longint'(tsn) - longint'(csn);
      den  = s1x * s2y - s2x * s1y;
      snum = s1x * dy - s1y * dx;
      tnum = s2x * dy - s2y * dx;
      c.hit        = 1'b0;
      c.t_fraction = '0;
      if (den != 0) begin
         // fold the sign of the denominator into both numerators
         if (den < 0) begin
            den  = -den;
            snum = -snum;
            tnum = -tnum;
         end
         if (snum >= 0 && snum < den && tnum >= 0 && tnum < den) begin
            c.hit = 1'b1;
            rem   = tnum;
            for (int i = 0; i < sip_pkg::FRAC_BITS; i++) begin
               rem          = rem * 2;
               c.t_fraction = c.t_fraction << 1;
               if (rem >= den) begin
                  rem             = rem - den;
                  c.t_fraction[0] = 1'b1;
               end
            end
         end
      end
      return c;
   endfunction

   always @(posedge clock) begin
      crossing_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (crossing_q.size() == 0) begin
               $error("result with no item waiting: hit %0d t_fraction %0d",
                      rsp_ch.hit, rsp_ch.t_fraction);
               fail_count = fail_count + 1;
            end else begin
               want = crossing_q.pop_front();
               if (rsp_ch.hit !== want.hit) begin
                  $error("hit: expected %0d, actual %0d", want.hit, rsp_ch.hit);
                  fail_count = fail_count + 1;
               end
               if (rsp_ch.t_fraction !== want.t_fraction) begin
                  $error("t_fraction: expected %0d, actual %0d",
                         want.t_fraction, rsp_ch.t_fraction);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            crossing_q = {crossing_q, intersect_pair(
               req_ch.track_start_east, req_ch.track_start_north,
               req_ch.track_end_east, req_ch.track_end_north,
               req_ch.contour_start_east, req_ch.contour_start_north,
               req_ch.contour_end_east, req_ch.contour_end_north)};
         end
      end
      pending = crossing_q.size();
   end

endmodule

// ===== tb/sv/segment_intersection_param_tb.sv =====
// segment_intersection_param_tb: stimulus, handshake pacing and verdict
// depends on sip_pkg, both channel interfaces, the block and its checker
`timescale 1ns / 1ps

module segment_intersection_param_tb;

   localparam int RANDOM_PAIRS = 1900;
   localparam int RESET_CYCLES = 12;
   // long receiver hold-off so the pipeline fills and req stalls
   localparam int HOLD_AFTER   = 600;
   localparam int HOLD_CYCLES  = 300;
   // number of pipeline stages plus margin for the tail
   localparam int DRAIN_CYCLES = sip_pkg::STAGES + 40;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int C_MAX        = 2 ** (sip_pkg::COORD_BITS - 1) - 1;
   localparam int C_MIN        = -(2 ** (sip_pkg::COORD_BITS - 1));

   typedef struct {
      sip_pkg::coord_type tse, tsn, tee, ten;
      sip_pkg::coord_type cse, csn, cee, cen;
   } seg_pair_type;

   logic clock = 1'b0;
   logic reset;
   int   sent_count = 0;
   int   burst_left = 0;
   int   cycle_count = 0;
   int   fail_count;
   int   pending;

   sip_req_if req_ch ();
   sip_rsp_if rsp_ch ();

   segment_intersection_param dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   segment_intersection_param_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case the block hangs or drops a result
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("segment_intersection_param_tb: errors");
         $finish;
      end
   end

   function automatic seg_pair_type make_pair(input int tse, input int tsn, input int tee,
                                              input int ten, input int cse, input int csn,
                                              input int cee, input int cen);
      seg_pair_type p;
      p.tse = sip_pkg::coord_type'(tse);
      p.tsn = sip_pkg::coord_type'(tsn);
      p.tee = sip_pkg::coord_type'(tee);
      p.ten = sip_pkg::coord_type'(ten);
      p.cse = sip_pkg::coord_type'(cse);
      p.csn = sip_pkg::coord_type'(csn);
      p.cee = sip_pkg::coord_type'(cee);
      p.cen = sip_pkg::coord_type'(cen);
      return p;
   endfunction

   // uniform value in [-2^sh, 2^sh - 1]
   function automatic int rand_span(input int sh);
      return int'($urandom_range(0, (2 << sh) - 1)) - (1 << sh);
   endfunction

   // offer one item at the falling edge, hold it until the block takes it
   task automatic send_pair(input seg_pair_type p);
      @(negedge clock);
      req_ch.valid               <= 1'b1;
      req_ch.track_start_east    <= p.tse;
      req_ch.track_start_north   <= p.tsn;
      req_ch.track_end_east      <= p.tee;
      req_ch.track_end_north     <= p.ten;
      req_ch.contour_start_east  <= p.cse;
      req_ch.contour_start_north <= p.csn;
      req_ch.contour_end_east    <= p.cee;
      req_ch.contour_end_north   <= p.cen;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_count++;
   endtask

   // bursts of back-to-back items separated by random gaps, sometimes none
   task automatic paced_send(input seg_pair_type p);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      send_pair(p);
   endtask

   // receiver: runs of differing ready density, plus one long hold-off
   initial begin : rsp_pattern
      int run_len;
      int ready_pct;
      bit held_off;
      held_off = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held_off && sent_count >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         run_len = $urandom_range(4, 60);
         case ($urandom_range(0, 3))
            0: begin
               ready_pct = 100;
            end
            1: begin
               ready_pct = 75;
            end
            2: begin
               ready_pct = 40;
            end
            default: begin
               ready_pct = 10;
            end
         endcase
         repeat (run_len) begin
            rsp_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
            @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      seg_pair_type directed[$];
      seg_pair_type p;
      int c[8];
      int kind, sh, idx;
      int px, py, ux, uy, vx, vy, ox, oy;
      int k1, k2, m1, m2;

      // every block input known from time zero
      reset                      = 1'b1;
      req_ch.valid               = 1'b0;
      req_ch.track_start_east    = '0;
      req_ch.track_start_north   = '0;
      req_ch.track_end_east      = '0;
      req_ch.track_end_north     = '0;
      req_ch.contour_start_east  = '0;
      req_ch.contour_start_north = '0;
      req_ch.contour_end_east    = '0;
      req_ch.contour_end_north   = '0;
      rsp_ch.ready               = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // plain crossing at mid track, and with the contour reversed (negative denominator)
      directed = {directed, make_pair(0, 0, 10, 0, 5, -5, 5, 5)};
      directed = {directed, make_pair(0, 0, 10, 0, 5, 5, 5, -5)};
      // contour through the track start point: t of zero still hits
      directed = {directed, make_pair(0, 0, 10, 0, 0, -5, 0, 5)};
      // contour through the track far end: t of one misses
      directed = {directed, make_pair(0, 0, 10, 0, 10, -5, 10, 5)};
      // contour starting on the track hits, contour ending on it misses
      directed = {directed, make_pair(0, 0, 10, 0, 5, 0, 5, 5)};
      directed = {directed, make_pair(0, 0, 10, 0, 5, -5, 5, 0)};
      // parallel and collinear overlapping
      directed = {directed, make_pair(0, 0, 10, 0, 0, 5, 10, 5)};
      directed = {directed, make_pair(0, 0, 10, 10, 5, 5, 20, 20)};
      // zero-length contour on the track, zero-length track, all zero
      directed = {directed, make_pair(0, 0, 10, 0, 5, 0, 5, 0)};
      directed = {directed, make_pair(3, 3, 3, 3, 0, -5, 0, 5)};
      directed = {directed, make_pair(0, 0, 0, 0, 0, 0, 0, 0)};
      // lines cross beyond the track far end
      directed = {directed, make_pair(0, 0, 10, 0, 20, -5, 20, 5)};
      // full-scale diagonals crossing near the origin
      directed = {directed,
                  make_pair(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN)};
      directed = {directed,
                  make_pair(C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX)};
      directed = {directed, make_pair(C_MIN, 0, C_MAX, 0, 0, C_MIN, 0, C_MAX)};
      // all corners at one extreme
      directed = {directed,
                  make_pair(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX)};
      directed = {directed,
                  make_pair(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN)};
      // t just under one and t so small that the fraction floors to zero
      directed = {directed, make_pair(0, 0, C_MAX, 0, C_MAX - 1, -1, C_MAX - 1, 1)};
      directed = {directed, make_pair(0, 0, C_MAX, 0, 1, -1, 1, 1)};
      // extreme track, short contour near its far end
      directed = {directed,
                  make_pair(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX - 2, C_MAX, C_MAX, C_MAX - 2)};

      foreach (directed[i]) paced_send(directed[i]);

      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         kind = $urandom_range(0, 99);
         px = rand_span(21);
         py = rand_span(21);
         sh = $urandom_range(0, 17);
         ux = rand_span(sh);
         uy = rand_span(sh);
         vx = rand_span(sh);
         vy = rand_span(sh);
         k1 = $urandom_range(0, 7);
         k2 = $urandom_range(0, 7);
         m1 = $urandom_range(0, 7);
         m2 = $urandom_range(0, 7);
         if (kind < 60) begin
            // both segments built through a common point: mostly hits
            c = '{px - k1 * ux, py - k1 * uy, px + k2 * ux, py + k2 * uy,
                  px - m1 * vx, py - m1 * vy, px + m2 * vx, py + m2 * vy};
            // near misses: nudge one endpoint by a unit
            if (kind >= 45) begin
               idx = $urandom_range(0, 7);
               c[idx] = c[idx] + (($urandom_range(0, 1) != 0) ? 1 : -1);
            end
         end else if (kind < 70) begin
            // same direction: collinear when the offset is zero, else parallel
            ox = (kind < 65) ? 0 : rand_span(sh);
            oy = (kind < 65) ? 0 : rand_span(sh);
            c = '{px, py, px + k2 * ux, py + k2 * uy,
                  px + ox - m1 * ux, py + oy - m1 * uy, px + ox + m2 * ux, py + oy + m2 * uy};
         end else if (kind < 80) begin
            // tiny grid, lots of touching and degenerate pairs
            foreach (c[i]) c[i] = rand_span(3);
         end else begin
            // full width noise covers every coordinate bit
            foreach (c[i]) c[i] = int'($urandom);
         end
         p = make_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
         paced_send(p);
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("segment_intersection_param_tb: clean");
      end else begin
         $display("segment_intersection_param_tb: errors");
      end
      $finish;
   end

endmodule
